/* rtl/core/hrrn_pkg.sv */
package hrrn_pkg;

   localparam int IdWidth     = 16;
   localparam int LenWidth    = 16;
   localparam int WaitWidth   = 32;
   localparam int StatusWidth = 3;
   localparam int CountWidth  = 5;

   typedef enum logic [StatusWidth-1:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_ZERO_LEN = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_SELECTED = 3'd4,
      ST_RAN      = 3'd5,
      ST_FINISHED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AGE,
      S_SCAN,
      S_MUL,
      S_CMP,
      S_RUN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic                 running;
      logic [IdWidth-1:0]   id;
      logic [LenWidth-1:0]  length;
      logic [LenWidth-1:0]  progress;
      logic [WaitWidth-1:0] wait_cnt;
   } entry_type;

   // Operation applied to the whole row of cells at once.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ADD,
      OP_AGE,
      OP_ROTATE,
      OP_SELECT,
      OP_ADVANCE,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [IdWidth-1:0]   new_id;
      logic [LenWidth-1:0]  new_length;
   } cell_ctrl_type;

endpackage

/* rtl/core/hrrn_cell.sv */
module hrrn_cell
   import hrrn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          add_here,
   input  logic          sel_here,
   input  logic          remove_shift,
   input  entry_type     from_right,
   output entry_type     entry
);

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_HOLD: ;
         OP_ADD: begin
            if (add_here) begin
               entry_in.valid    = 1'b1;
               entry_in.running  = 1'b0;
               entry_in.id       = ctrl.new_id;
               entry_in.length   = ctrl.new_length;
               entry_in.progress = '0;
               entry_in.wait_cnt = '0;
            end
         end
         OP_AGE: begin
            if (entry_ff.valid && !entry_ff.running && !(&entry_ff.wait_cnt))
               entry_in.wait_cnt = entry_ff.wait_cnt + 1'b1;
         end
         OP_ROTATE: entry_in = from_right;
         OP_SELECT: begin
            if (sel_here) entry_in.running = 1'b1;
         end
         OP_ADVANCE: begin
            if (entry_ff.valid && entry_ff.running)
               entry_in.progress = entry_ff.progress + 1'b1;
         end
         OP_REMOVE: begin
            if (remove_shift) entry_in = from_right;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid   <= 1'b0;
         entry_ff.running <= 1'b0;
      end else begin
         entry_ff.valid   <= entry_in.valid;
         entry_ff.running <= entry_in.running;
      end
      entry_ff.id       <= entry_in.id;
      entry_ff.length   <= entry_in.length;
      entry_ff.progress <= entry_in.progress;
      entry_ff.wait_cnt <= entry_in.wait_cnt;
   end

   assign entry = entry_ff;

endmodule

/* rtl/core/hrrn_task_scheduler.sv */
// HRRN task scheduler.
// Requests enter on req_valid/req_stall with req_command and req_task_length.
// Each request yields exactly one response on rsp_valid/rsp_stall carrying
// rsp_status, rsp_task_id and rsp_task_count.
// An add request goes from S_IDLE straight to S_RESP, which makes its response
// valid once no earlier response is still stalled. A tick on an empty table goes through S_AGE to S_RESP.
// A tick that advances the running task ages the table in S_AGE. It then
// rotates the table once through the cell row in S_SCAN to find the running
// slot, advances that task in S_RUN and answers from S_RESP.
// A tick that selects among n tasks also scans them, passing each task after the
// first through S_MUL, where two 32x16 products are registered, and then S_CMP,
// which compares them; S_RESP then rotates the table home before it answers.
// One request is in work at a time. The next request can be taken as soon as
// a response is made valid, while that response still waits.
// Reset empties the table and restarts task ids at one.
// When the receiver stalls, the response holds; the next request is still taken
// and worked on, but waits in S_RESP until that response is accepted.
module hrrn_task_scheduler
   import hrrn_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [LenWidth-1:0]    req_task_length,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [IdWidth-1:0]     rsp_task_id,
   output logic [CountWidth-1:0]  rsp_task_count
);

   localparam int IdxW = $clog2(MAX_TASKS);
   localparam int CntW = $clog2(MAX_TASKS + 1);

   state_type state_ff, state_in;
   entry_type cells [MAX_TASKS];
   cell_ctrl_type ctrl;
   logic [MAX_TASKS-1:0] add_here, sel_here, rm_shift;

   logic                 cmd_ff, cmd_in;
   logic [LenWidth-1:0]  len_ff, len_in;
   logic [IdWidth-1:0]   next_id_ff, next_id_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [CntW-1:0]      step_ff, step_in;
   logic [IdxW-1:0]      best_ff, best_in;
   logic [WaitWidth-1:0] bwait_ff, bwait_in;
   logic [LenWidth-1:0]  blen_ff, blen_in;
   logic [WaitWidth+LenWidth-1:0] lhs_ff, rhs_ff;
   logic [IdxW-1:0]      run_ff, run_in;
   logic                 have_run_ff, have_run_in;

   logic                   rv_ff, rv_in;
   logic [StatusWidth-1:0] rs_ff, rs_in;
   logic [IdWidth-1:0]     rid_ff, rid_in;
   logic [CntW-1:0]        rc_ff, rc_in;

   entry_type head;
   assign head = cells[0];

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      entry_type right;
      if (g == MAX_TASKS - 1) begin : g_last
         // Rotation wraps the head back; removal shifts in an empty slot.
         always_comb begin
            right = cells[0];
            if (ctrl.op == OP_REMOVE) begin
               right.valid   = 1'b0;
               right.running = 1'b0;
            end
         end
      end else begin : g_mid
         assign right = cells[g+1];
      end
      assign add_here[g] = (CntW'(g) == count_ff);
      assign sel_here[g] = (IdxW'(g) == best_ff);
      assign rm_shift[g] = (IdxW'(g) >= run_ff);
      hrrn_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .add_here    (add_here[g]),
         .sel_here    (sel_here[g]),
         .remove_shift(rm_shift[g]),
         .from_right  (right),
         .entry       (cells[g])
      );
   end

   entry_type run_e;
   assign run_e = cells[run_ff];

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      next_id_in  = next_id_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      best_in     = best_ff;
      bwait_in    = bwait_ff;
      blen_in     = blen_ff;
      run_in      = run_ff;
      have_run_in = have_run_ff;
      rv_in       = rv_ff && rsp_stall;
      rs_in       = rs_ff;
      rid_in      = rid_ff;
      rc_in       = rc_ff;
      ctrl.op         = OP_HOLD;
      ctrl.new_id     = next_id_ff;
      ctrl.new_length = len_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in = req_command;
               len_in = req_task_length;
               state_in = req_command ? S_AGE : S_RESP;
               step_in = '0;
               have_run_in = 1'b0;
            end
         end
         S_AGE: begin
            // Age all waiting cells unless the table is empty; S_SCAN then finds the running slot in one rotation pass.
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else begin
               ctrl.op = OP_AGE;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (step_ff == CntW'(MAX_TASKS)) begin
               step_in = '0;
               if (have_run_ff) begin
                  state_in = S_RUN;
               end else begin
                  best_in  = '0;
                  bwait_in = head.wait_cnt;
                  blen_in  = head.length;
                  step_in  = CntW'(1);
                  ctrl.op  = OP_ROTATE;
                  state_in = (count_ff > CntW'(1)) ? S_MUL : S_RESP;
               end
            end else begin
               if (head.valid && head.running) begin
                  have_run_in = 1'b1;
                  run_in = step_ff[IdxW-1:0];
               end
               ctrl.op = OP_ROTATE;
               step_in = step_ff + 1'b1;
            end
         end
         S_MUL: state_in = S_CMP;
         S_CMP: begin
            if (lhs_ff > rhs_ff) begin
               best_in  = step_ff[IdxW-1:0];
               bwait_in = head.wait_cnt;
               blen_in  = head.length;
            end
            step_in = step_ff + 1'b1;
            ctrl.op = OP_ROTATE;
            state_in = (step_ff + 1'b1 == count_ff) ? S_RESP : S_MUL;
         end
         S_RUN: begin
            ctrl.op  = OP_ADVANCE;
            state_in = S_RESP;
         end
         S_RESP: begin
            // Finish the request; rotate leftover scan positions home first.
            if (cmd_ff && !have_run_ff && count_ff != '0 && step_ff != CntW'(MAX_TASKS)) begin
               ctrl.op = OP_ROTATE;
               step_in = step_ff + 1'b1;
            end else if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               rid_in = '0;
               state_in = S_IDLE;
               if (!cmd_ff) begin
                  if (count_ff == CntW'(MAX_TASKS)) begin
                     rs_in = ST_FULL;
                  end else if (len_ff == '0) begin
                     rs_in = ST_ZERO_LEN;
                  end else begin
                     ctrl.op = OP_ADD;
                     rs_in = ST_ADDED;
                     rid_in = next_id_ff;
                     next_id_in = next_id_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rs_in = ST_EMPTY;
               end else if (!have_run_ff) begin
                  ctrl.op = OP_SELECT;
                  rs_in = ST_SELECTED;
                  rid_in = cells[best_ff].id;
               end else begin
                  rid_in = run_e.id;
                  if (run_e.progress == run_e.length) begin
                     ctrl.op = OP_REMOVE;
                     rs_in = ST_FINISHED;
                     count_in = count_ff - 1'b1;
                  end else begin
                     rs_in = ST_RAN;
                  end
               end
               rc_in = count_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         next_id_ff <= IdWidth'(1);
         count_ff   <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
         count_ff   <= count_in;
         rv_ff      <= rv_in;
      end
      cmd_ff      <= cmd_in;
      len_ff      <= len_in;
      step_ff     <= step_in;
      best_ff     <= best_in;
      bwait_ff    <= bwait_in;
      blen_ff     <= blen_in;
      run_ff      <= run_in;
      have_run_ff <= have_run_in;
      rs_ff       <= rs_in;
      rid_ff      <= rid_in;
      rc_ff       <= rc_in;
      lhs_ff      <= head.wait_cnt * blen_ff;
      rhs_ff      <= bwait_ff * head.length;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_task_id    = rid_ff;
   assign rsp_task_count = CountWidth'(rc_ff);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import hrrn_pkg::*;

   localparam int NumSlots = 16;
   localparam int CycleLimit = 2000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = 1'b0;
   logic [LenWidth-1:0]    req_task_length = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [IdWidth-1:0]     rsp_task_id;
   logic [CountWidth-1:0]  rsp_task_count;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IdWidth-1:0]     id;
      logic [CountWidth-1:0]  count;
   } outcome_type;

   // Shadow of the task table, oldest task at slot 0.
   logic                 sh_valid[NumSlots];
   logic                 sh_running[NumSlots];
   logic [IdWidth-1:0]   sh_id[NumSlots];
   logic [LenWidth-1:0]  sh_length[NumSlots];
   logic [LenWidth-1:0]  sh_progress[NumSlots];
   logic [WaitWidth-1:0] sh_wait[NumSlots];
   logic [IdWidth-1:0]   sh_next_id;

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   int          unexpected_count = 0;
   int          response_count = 0;
   int          request_count = 0;
   int          cycle_count = 0;
   int          hold_off_cycles = 0;
   bit          stall_pattern_on = 1'b1;
   int          status_seen[8];

   hrrn_task_scheduler #(.MAX_TASKS(NumSlots)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_task_length(req_task_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_task_id    (rsp_task_id),
      .rsp_task_count (rsp_task_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int table_count();
      int n;
      n = 0;
      for (int i = 0; i < NumSlots; i++) if (sh_valid[i]) n++;
      return n;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < NumSlots; i++) begin
         sh_valid[i] = 1'b0;
         sh_running[i] = 1'b0;
         sh_id[i] = '0;
         sh_length[i] = '0;
         sh_progress[i] = '0;
         sh_wait[i] = '0;
      end
      sh_next_id = IdWidth'(1);
   endfunction

   function automatic outcome_type make_outcome(status_type st, logic [IdWidth-1:0] id);
      outcome_type o;
      o.status = st;
      o.id = id;
      o.count = CountWidth'(table_count());
      return o;
   endfunction

   function automatic outcome_type schedule_step(logic cmd, logic [LenWidth-1:0] len);
      int n, best, run;
      bit have_run;
      logic [63:0] lhs, rhs;
      logic [IdWidth-1:0] done_id;
      n = table_count();
      if (cmd == 1'b0) begin
         if (n >= NumSlots) return make_outcome(ST_FULL, '0);
         if (len == 0) return make_outcome(ST_ZERO_LEN, '0);
         sh_valid[n] = 1'b1;
         sh_running[n] = 1'b0;
         sh_id[n] = sh_next_id;
         sh_length[n] = len;
         sh_progress[n] = '0;
         sh_wait[n] = '0;
         sh_next_id = sh_next_id + 1'b1;
         return make_outcome(ST_ADDED, sh_id[n]);
      end
      if (n == 0) return make_outcome(ST_EMPTY, '0);
      have_run = 1'b0;
      run = 0;
      for (int i = 0; i < n; i++) begin
         if (sh_running[i]) begin
            have_run = 1'b1;
            run = i;
         end else if (sh_wait[i] != '1) begin
            sh_wait[i] = sh_wait[i] + 1'b1;
         end
      end
      if (!have_run) begin
         best = 0;
         for (int i = 1; i < n; i++) begin
            lhs = 64'(sh_wait[i]) * 64'(sh_length[best]);
            rhs = 64'(sh_wait[best]) * 64'(sh_length[i]);
            if (lhs > rhs) best = i;
         end
         sh_running[best] = 1'b1;
         return make_outcome(ST_SELECTED, sh_id[best]);
      end
      sh_progress[run] = sh_progress[run] + 1'b1;
      if (sh_progress[run] == sh_length[run]) begin
         done_id = sh_id[run];
         for (int i = run; i + 1 < NumSlots; i++) begin
            sh_valid[i] = sh_valid[i+1];
            sh_running[i] = sh_running[i+1];
            sh_id[i] = sh_id[i+1];
            sh_length[i] = sh_length[i+1];
            sh_progress[i] = sh_progress[i+1];
            sh_wait[i] = sh_wait[i+1];
         end
         sh_valid[NumSlots-1] = 1'b0;
         sh_running[NumSlots-1] = 1'b0;
         return make_outcome(ST_FINISHED, done_id);
      end
      return make_outcome(ST_RAN, sh_id[run]);
   endfunction

   // Sends one request; the prediction is made when it is accepted.
   task automatic send_request(logic cmd, logic [LenWidth-1:0] len);
      outcome_type o;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_task_length <= len;
      do @(posedge clock); while (req_stall);
      o = schedule_step(cmd, len);
      pending_outcomes.insert(pending_outcomes.size(), o);
      request_count++;
   endtask

   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic random_burst(int items, int tick_weight, bit short_len);
      int burst;
      logic [LenWidth-1:0] len;
      while (items > 0) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && items > 0; k++) begin
            case ($urandom_range(0, 15))
               0: len = '0;
               1: len = LenWidth'($urandom);
               2: len = '1;
               default: len = short_len ? LenWidth'($urandom_range(1, 6))
                                        : LenWidth'($urandom_range(1, 40));
            endcase
            send_request($urandom_range(0, 99) < tick_weight, len);
            items--;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 6));
      end
      idle_gap(1);
   endtask

   task automatic test_directed_cases();
      send_request(1'b1, 16'h0000);
      send_request(1'b0, 16'h0000);
      send_request(1'b0, 16'h0003);
      send_request(1'b0, 16'h0001);
      send_request(1'b1, 16'hFFFF);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'h0000);
      send_request(1'b0, 16'hFFFF);
      send_request(1'b0, 16'h8000);
      send_request(1'b0, 16'h7FFF);
      for (int i = 0; i < 14; i++) send_request(1'b0, 16'h0002);
      send_request(1'b0, 16'h0005);
      send_request(1'b0, 16'h0000);
      idle_gap(1);
   endtask

   task automatic test_drain_table();
      bit long_left;
      long_left = 1'b0;
      while (table_count() != 0 && !long_left) begin
         send_request(1'b1, LenWidth'($urandom));
         // Tasks too long to run out in a short run stay in the table.
         for (int i = 0; i < NumSlots; i++)
            if (sh_valid[i] && sh_length[i] > 100) long_left = 1'b1;
      end
      idle_gap(1);
   endtask

   task automatic test_short_tasks();
      // Adds one-tick tasks and ticks them through selection and completion.
      for (int i = 0; i < 20; i++) begin
         send_request(1'b0, 16'h0001);
         send_request(1'b1, 16'h0000);
         send_request(1'b1, 16'h0000);
      end
   endtask

   task automatic test_back_pressure();
      hold_off_cycles = 400;
      for (int i = 0; i < 40; i++) send_request(1'($urandom_range(0, 1)), 16'h0002);
      idle_gap(1);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (!stall_pattern_on) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ((cycle_count % 23) < 5) || ($urandom_range(0, 7) == 0);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         status_seen[rsp_status]++;
         if (pending_outcomes.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("Unexpected response status %0d id %0d", rsp_status, rsp_task_id);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_task_id !== want.id ||
                rsp_task_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           want.status, want.id, want.count,
                           rsp_status, rsp_task_id, rsp_task_count);
            end
         end
      end
   end

   initial begin
      clear_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_back_pressure();
      test_short_tasks();
      random_burst(400, 50, 1'b1);
      random_burst(400, 30, 1'b1);
      random_burst(200, 70, 1'b0);
      stall_pattern_on = 1'b0;
      random_burst(200, 50, 1'b1);
      stall_pattern_on = 1'b1;
      random_burst(200, 20, 1'b1);
      test_drain_table();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (3 * NumSlots + 20) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses; added %0d, full %0d, zero %0d,",
               request_count, response_count, status_seen[ST_ADDED], status_seen[ST_FULL],
               status_seen[ST_ZERO_LEN]);
      $display("empty %0d, selected %0d, ran %0d, finished %0d.", status_seen[ST_EMPTY],
               status_seen[ST_SELECTED], status_seen[ST_RAN], status_seen[ST_FINISHED]);
      if (mismatch_count == 0 && unexpected_count == 0 && pending_outcomes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d unexpected", mismatch_count, unexpected_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
